// File: sv/gasp_pkg.sv
// gasp_pkg: shared types, constants and codes of the glyph atlas shelf packer
// no dependencies; used by the top level, front, back and testbench
`timescale 1ns / 1ps

package gasp_pkg;

  localparam int CODE_COUNT_DEF = 65536;
  localparam int MAX_LINES_DEF  = 512;
  localparam int MAX_SHEETS_DEF = 16;

  localparam int EPOCH_W = 5;
  localparam int FILL_W  = 13;

  localparam logic [15:0] EMPTY_ENTRY = 16'hFFFF;
  localparam logic [16:0] INDEX_LIMIT = 17'h0FFFF;
  localparam logic [7:0]  PAD         = 8'd2;
  localparam logic [7:0]  MAX_GLYPH   = 8'd253;

  localparam logic [12:0] SHEET_W_RST = 13'd256;
  localparam logic [8:0]  LINE_H_RST  = 9'd18;
  localparam logic [9:0]  LINES_RST   = 10'd14;

  typedef enum logic [1:0] {
    REG_SHEET_W = 2'd0,
    REG_LINE_H  = 2'd1,
    REG_LINES   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NEW  = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic [7:0]  cell_width;
    logic        out_of_range;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } queue_head_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] glyph_index;
    logic [3:0]  sheet_number;
    logic [11:0] x_left;
    logic [12:0] y_top;
    logic [12:0] x_right;
    logic [12:0] y_bottom;
    logic [7:0]  cell_width;
  } result_t;

endpackage

// File: sv/gasp_if.sv
// gasp_if: valid/ready channel interfaces for glyph items and placement results
// depends on nothing
`timescale 1ns / 1ps

interface gasp_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       char_code;
  logic [7:0]        glyph_width;
  logic signed [7:0] left_space;
  logic signed [7:0] right_space;

  modport source (output valid, char_code, glyph_width, left_space, right_space,
                  input ready);
  modport sink (input valid, char_code, glyph_width, left_space, right_space,
                output ready);
endinterface

interface gasp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] glyph_index;
  logic [3:0]  sheet_number;
  logic [11:0] x_left;
  logic [12:0] y_top;
  logic [12:0] x_right;
  logic [12:0] y_bottom;
  logic [7:0]  cell_width;

  modport source (output valid, status, glyph_index, sheet_number, x_left, y_top,
                  x_right, y_bottom, cell_width, input ready);
  modport sink (input valid, status, glyph_index, sheet_number, x_left, y_top,
                x_right, y_bottom, cell_width, output ready);
endinterface

// File: sv/glyph_atlas_shelf_packer.sv
// channel   dir   handshake            payload
// in_ch     in    valid/ready          char_code, glyph_width, left_space, right_space
// out_ch    out   valid/ready          status, glyph_index, sheet_number, coords, cell_width
// cfg_*     in    apb write/read       sheet_width, line_height, lines_per_sheet
// after reset the index and line tables clear, one entry a cycle
// out of range code: idle, then emit; duplicate, or full already known: idle, look, emit
// new code: idle, look, then scan line by line; a full sheet opens the next within scan
// a two entry queue takes items while the scan runs; result register holds under stall
// top level: config registers, front and back; depends on gasp_pkg, gasp_if, submodules
`timescale 1ns / 1ps

module glyph_atlas_shelf_packer #(
  parameter int CODE_COUNT = gasp_pkg::CODE_COUNT_DEF,
  parameter int MAX_LINES  = gasp_pkg::MAX_LINES_DEF,
  parameter int MAX_SHEETS = gasp_pkg::MAX_SHEETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gasp_in_if.sink     in_ch,
  gasp_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [12:0]           sheet_w_r;
  logic [8:0]            line_h_r;
  logic [9:0]            lines_r;
  logic                  cfg_wr;
  gasp_pkg::reg_idx_t    cfg_idx;
  gasp_pkg::queue_head_t head;
  logic                  pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = gasp_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_w_r <= gasp_pkg::SHEET_W_RST;
      line_h_r  <= gasp_pkg::LINE_H_RST;
      lines_r   <= gasp_pkg::LINES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gasp_pkg::REG_SHEET_W: sheet_w_r <= cfg_pwdata[12:0];
        gasp_pkg::REG_LINE_H:  line_h_r  <= cfg_pwdata[8:0];
        gasp_pkg::REG_LINES:   lines_r   <= cfg_pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gasp_pkg::REG_SHEET_W: cfg_prdata = 32'(sheet_w_r);
      gasp_pkg::REG_LINE_H:  cfg_prdata = 32'(line_h_r);
      gasp_pkg::REG_LINES:   cfg_prdata = 32'(lines_r);
      default:               cfg_prdata = 32'd0;
    endcase
  end

  gasp_front #(.CODE_COUNT(CODE_COUNT)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  gasp_back #(
    .CODE_COUNT (CODE_COUNT),
    .MAX_LINES  (MAX_LINES),
    .MAX_SHEETS (MAX_SHEETS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .sheet_width     (sheet_w_r),
    .line_height     (line_h_r),
    .lines_per_sheet (lines_r),
    .out_ch          (out_ch)
  );

endmodule

// File: sv/gasp_ram.sv
// gasp_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module gasp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/gasp_front.sv
// gasp_front: accepts glyph items, pads and range checks them, two entry queue
// depends on gasp_pkg and gasp_if
`timescale 1ns / 1ps

module gasp_front #(
  parameter int CODE_COUNT = gasp_pkg::CODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gasp_in_if.sink               in_ch,
  output gasp_pkg::queue_head_t head,
  input  logic                  pop
);

  gasp_pkg::work_t q_r [2];
  logic [1:0]      cnt_r;
  logic            rd_r;
  logic            wr_r;
  logic            push;
  logic            pop_ok;
  logic [7:0]      gw;
  gasp_pkg::work_t item;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop_ok      = pop && (cnt_r != 2'd0);

  always_comb begin
    gw = (in_ch.glyph_width > gasp_pkg::MAX_GLYPH) ? gasp_pkg::MAX_GLYPH : in_ch.glyph_width;
    item.char_code    = in_ch.char_code;
    item.cell_width   = gw + gasp_pkg::PAD;
    item.out_of_range = ({1'b0, in_ch.char_code} >= 17'(CODE_COUNT));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= item;
    end
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop_ok) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop_ok);
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_r];

endmodule

// File: sv/gasp_back.sv
// gasp_back: index table lookup, first fit line scan and sheet sequencing
// depends on gasp_pkg, gasp_if and gasp_ram
`timescale 1ns / 1ps

module gasp_back #(
  parameter int CODE_COUNT = gasp_pkg::CODE_COUNT_DEF,
  parameter int MAX_LINES  = gasp_pkg::MAX_LINES_DEF,
  parameter int MAX_SHEETS = gasp_pkg::MAX_SHEETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gasp_pkg::queue_head_t head,
  output logic                  pop,
  input  logic [12:0]           sheet_width,
  input  logic [8:0]            line_height,
  input  logic [9:0]            lines_per_sheet,
  gasp_out_if.source            out_ch
);

  localparam int CA_W  = $clog2(CODE_COUNT);
  localparam int LA_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CLR_D = (CODE_COUNT > MAX_LINES) ? CODE_COUNT : MAX_LINES;
  localparam int CLR_W = $clog2(CLR_D);
  localparam int LR_W  = gasp_pkg::EPOCH_W + gasp_pkg::FILL_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_SCAN, S_EMIT} state_t;

  state_t                         state_r, state_nxt;
  logic [CLR_W-1:0]               clr_r, clr_nxt;
  logic [15:0]                    code_r, code_nxt;
  logic [7:0]                     cw_r, cw_nxt;
  logic [LA_W-1:0]                line_r, line_nxt;
  logic [12:0]                    y_r, y_nxt;
  logic [gasp_pkg::EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic [3:0]                     sheet_r, sheet_nxt;
  logic [16:0]                    next_r, next_nxt;
  logic                           full_r, full_nxt;
  gasp_pkg::result_t              res_r, res_nxt;
  gasp_pkg::result_t              out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic                           code_we;
  logic [CA_W-1:0]                code_wa;
  logic [15:0]                    code_wd;
  logic [15:0]                    code_rd;
  logic                           line_we;
  logic [LA_W-1:0]                line_wa;
  logic [LR_W-1:0]                line_wd;
  logic [LR_W-1:0]                line_rd;

  logic [9:0]                     lines_eff;
  logic [12:0]                    fill;
  logic [13:0]                    sum;
  logic                           place;
  gasp_pkg::result_t              res_full;

  gasp_ram #(.WIDTH(16), .DEPTH(CODE_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (code_wa),
    .wdata (code_wd),
    .raddr (head.item.char_code[CA_W-1:0]),
    .rdata (code_rd)
  );

  gasp_ram #(.WIDTH(LR_W), .DEPTH(MAX_LINES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_wa),
    .wdata (line_wd),
    .raddr (line_nxt),
    .rdata (line_rd)
  );

  always_comb begin
    if (lines_per_sheet == 10'd0) begin
      lines_eff = 10'd1;
    end else if ({1'b0, lines_per_sheet} > 11'(MAX_LINES)) begin
      lines_eff = 10'(MAX_LINES);
    end else begin
      lines_eff = lines_per_sheet;
    end
    fill  = (line_rd[LR_W-1:gasp_pkg::FILL_W] == epoch_r) ? line_rd[gasp_pkg::FILL_W-1:0]
                                                            : 13'd0;
    sum   = {1'b0, fill} + 14'(cw_r);
    place = (state_r == S_SCAN) && (sum < {1'b0, sheet_width});
    res_full              = '0;
    res_full.status       = gasp_pkg::ST_FULL;
    res_full.cell_width   = cw_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    code_nxt      = code_r;
    cw_nxt        = cw_r;
    line_nxt      = line_r;
    y_nxt         = y_r;
    epoch_nxt     = epoch_r;
    sheet_nxt     = sheet_r;
    next_nxt      = next_r;
    full_nxt      = full_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop           = 1'b0;
    code_we       = 1'b0;
    code_wa       = code_r[CA_W-1:0];
    code_wd       = next_r[15:0];
    line_we       = 1'b0;
    line_wa       = line_r;
    line_wd       = {epoch_r, sum[12:0]};

    case (state_r)
      S_CLEAR: begin
        code_we = ({1'b0, clr_r} < (CLR_W + 1)'(CODE_COUNT));
        code_wa = clr_r[CA_W-1:0];
        code_wd = gasp_pkg::EMPTY_ENTRY;
        line_we = ({1'b0, clr_r} < (CLR_W + 1)'(MAX_LINES));
        line_wa = clr_r[LA_W-1:0];
        line_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_D - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          code_nxt = head.item.char_code;
          cw_nxt   = head.item.cell_width;
          if (head.item.out_of_range) begin
            res_nxt            = '0;
            res_nxt.status     = gasp_pkg::ST_FULL;
            res_nxt.cell_width = head.item.cell_width;
            state_nxt          = S_EMIT;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        line_nxt = '0;
        y_nxt    = 13'd0;
        if (code_rd != gasp_pkg::EMPTY_ENTRY) begin
          res_nxt             = '0;
          res_nxt.status      = gasp_pkg::ST_DUP;
          res_nxt.glyph_index = code_rd;
          res_nxt.cell_width  = cw_r;
          state_nxt           = S_EMIT;
        end else if (full_r || next_r >= gasp_pkg::INDEX_LIMIT) begin
          full_nxt  = 1'b1;
          res_nxt   = res_full;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (place) begin
          code_we              = 1'b1;
          line_we              = 1'b1;
          next_nxt             = next_r + 17'd1;
          res_nxt.status       = gasp_pkg::ST_NEW;
          res_nxt.glyph_index  = next_r[15:0];
          res_nxt.sheet_number = sheet_r;
          res_nxt.x_left       = fill[11:0];
          res_nxt.y_top        = y_r;
          res_nxt.x_right      = sum[12:0];
          res_nxt.y_bottom     = y_r + 13'(line_height);
          res_nxt.cell_width   = cw_r;
          state_nxt            = S_EMIT;
        end else if (10'(line_r) + 10'd1 < lines_eff) begin
          line_nxt = line_r + 1'b1;
          y_nxt    = y_r + 13'(line_height);
        end else begin
          epoch_nxt = epoch_r + 1'b1;
          line_nxt  = '0;
          y_nxt     = 13'd0;
          if (5'(sheet_r) + 5'd2 >= 5'(MAX_SHEETS)) begin
            full_nxt  = 1'b1;
            res_nxt   = res_full;
            state_nxt = S_EMIT;
          end else begin
            sheet_nxt = sheet_r + 4'd1;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    cw_r   <= cw_nxt;
    line_r <= line_nxt;
    y_r    <= y_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      epoch_r     <= '0;
      sheet_r     <= 4'd0;
      next_r      <= 17'd0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      epoch_r     <= epoch_nxt;
      sheet_r     <= sheet_nxt;
      next_r      <= next_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.glyph_index  = out_r.glyph_index;
  assign out_ch.sheet_number = out_r.sheet_number;
  assign out_ch.x_left       = out_r.x_left;
  assign out_ch.y_top        = out_r.y_top;
  assign out_ch.x_right      = out_r.x_right;
  assign out_ch.y_bottom     = out_r.y_bottom;
  assign out_ch.cell_width   = out_r.cell_width;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop)
    else $error("item taken during table clear");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("full status dropped");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    place |=> (next_r == $past(next_r) + 17'd1))
    else $error("entry index did not advance on placement");

endmodule

// File: bench/testbench.sv
// testbench for glyph_atlas_shelf_packer: random and directed glyph items with an
// in-bench placement predictor, apb register phases and random stalls on both channels
// depends on gasp_pkg, gasp_if and the rtl of the block
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [15:0]       code;
    logic [7:0]        gw;
    logic signed [7:0] ls;
    logic signed [7:0] rs;
  } glyph_req_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gasp_in_if  in_bus ();
  gasp_out_if out_bus ();

  glyph_atlas_shelf_packer uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [15:0] index_of_code [gasp_pkg::CODE_COUNT_DEF];
  int unsigned shelf_fill [gasp_pkg::MAX_LINES_DEF];
  int unsigned sheet_now;
  int unsigned index_next;
  bit          packed_full;
  int unsigned sheet_w_q;
  int unsigned line_h_q;
  int unsigned lines_q;

  glyph_req_t        pending_glyphs[$];
  gasp_pkg::result_t expected_places[$];
  logic [15:0]       sent_codes[$];
  glyph_req_t        cur_glyph;
  bit                took;
  int                idle_mode;
  int                accepted;
  int                results_seen;
  int                errs;
  int                n_new, n_dup, n_full;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic gasp_pkg::result_t place_glyph(input glyph_req_t g);
    gasp_pkg::result_t r;
    int unsigned       gw, cw, lines, fill, yt;
    bit                done;
    gw = g.gw;
    if (gw > gasp_pkg::MAX_GLYPH) gw = gasp_pkg::MAX_GLYPH;
    cw = gw + gasp_pkg::PAD;
    r = '0;
    r.cell_width = cw[7:0];
    r.status = gasp_pkg::ST_FULL;
    if (index_of_code[g.code] != gasp_pkg::EMPTY_ENTRY) begin
      r.status = gasp_pkg::ST_DUP;
      r.glyph_index = index_of_code[g.code];
      return r;
    end
    if (!packed_full && index_next >= gasp_pkg::EMPTY_ENTRY) packed_full = 1'b1;
    if (packed_full) return r;
    lines = lines_q;
    if (lines == 0) lines = 1;
    if (lines > gasp_pkg::MAX_LINES_DEF) lines = gasp_pkg::MAX_LINES_DEF;
    done = 1'b0;
    for (int a = 0; a <= gasp_pkg::MAX_SHEETS_DEF && !done; a++) begin
      for (int ln = 0; ln < lines && !done; ln++) begin
        fill = shelf_fill[ln];
        if (fill + cw < sheet_w_q) begin
          yt = ln * line_h_q;
          index_of_code[g.code] = index_next[15:0];
          r.status = gasp_pkg::ST_NEW;
          r.glyph_index = index_next[15:0];
          r.sheet_number = sheet_now[3:0];
          r.x_left = fill[11:0];
          r.y_top = yt[12:0];
          r.x_right = 13'(fill + cw);
          r.y_bottom = 13'(yt + line_h_q);
          index_next = (index_next + 1) & 32'h1FFFF;
          shelf_fill[ln] = (fill + cw) & 32'h1FFF;
          done = 1'b1;
        end
      end
      if (!done) begin
        foreach (shelf_fill[i]) shelf_fill[i] = 0;
        if (sheet_now + 2 >= gasp_pkg::MAX_SHEETS_DEF) begin
          packed_full = 1'b1;
          return r;
        end
        sheet_now = (sheet_now + 1) & 4'hF;
      end
    end
    if (!done) packed_full = 1'b1;
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    if (!in_bus.valid || took) begin
      if (pending_glyphs.size() > 0 && !(idle_mode == 0 && $urandom_range(99) < 10)
          && !(idle_mode == 1 && $urandom_range(99) < 63)) begin
        cur_glyph = pending_glyphs.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.char_code <= cur_glyph.code;
        in_bus.glyph_width <= cur_glyph.gw;
        in_bus.left_space <= cur_glyph.ls;
        in_bus.right_space <= cur_glyph.rs;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    if (idle_mode == 0) out_bus.ready <= ($urandom_range(99) >= 63);
    else if (idle_mode == 1) out_bus.ready <= ($urandom_range(99) >= 10);
    else out_bus.ready <= 1'b1;
  end

  always @(posedge clk) begin
    took <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      expected_places.push_back(place_glyph(cur_glyph));
      accepted <= accepted + 1;
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    gasp_pkg::result_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (expected_places.size() == 0) begin
        $error("result item with nothing expected");
        errs++;
      end else begin
        e = expected_places.pop_front();
        case (e.status)
          gasp_pkg::ST_NEW: n_new++;
          gasp_pkg::ST_DUP: n_dup++;
          default: n_full++;
        endcase
        check_field("status", e.status, out_bus.status);
        check_field("glyph_index", e.glyph_index, out_bus.glyph_index);
        check_field("sheet_number", e.sheet_number, out_bus.sheet_number);
        check_field("x_left", e.x_left, out_bus.x_left);
        check_field("y_top", e.y_top, out_bus.y_top);
        check_field("x_right", e.x_right, out_bus.x_right);
        check_field("y_bottom", e.y_bottom, out_bus.y_bottom);
        check_field("cell_width", e.cell_width, out_bus.cell_width);
      end
    end
  end

  always @(posedge clk) begin
    if (accepted < 530) idle_mode <= 0;
    else if (accepted < 1060) idle_mode <= 1;
    else idle_mode <= 2;
  end

  task automatic apb_write(input gasp_pkg::reg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 4'(idx * 4);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      gasp_pkg::REG_SHEET_W: sheet_w_q = value & 32'h1FFF;
      gasp_pkg::REG_LINE_H:  line_h_q = value & 32'h1FF;
      default:               lines_q = value & 32'h3FF;
    endcase
  endtask

  task automatic add_glyph(input logic [15:0] code, input logic [7:0] gw,
                           input logic [7:0] ls, input logic [7:0] rs);
    glyph_req_t g;
    g.code = code;
    g.gw = gw;
    g.ls = ls;
    g.rs = rs;
    pending_glyphs.push_back(g);
    sent_codes.push_back(code);
  endtask

  task automatic add_random(input int n);
    logic [15:0] code;
    for (int i = 0; i < n; i++) begin
      if (sent_codes.size() > 0 && $urandom_range(99) < 35)
        code = sent_codes[$urandom_range(sent_codes.size() - 1)];
      else
        code = 16'($urandom_range(16'hFFFF));
      add_glyph(code, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end
  endtask

  task automatic drain;
    while (pending_glyphs.size() != 0 || in_bus.valid || expected_places.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    foreach (index_of_code[i]) index_of_code[i] = gasp_pkg::EMPTY_ENTRY;
    foreach (shelf_fill[i]) shelf_fill[i] = 0;
    sheet_now = 0;
    index_next = 0;
    packed_full = 1'b0;
    sheet_w_q = gasp_pkg::SHEET_W_RST;
    line_h_q = gasp_pkg::LINE_H_RST;
    lines_q = gasp_pkg::LINES_RST;
    took = 1'b0;
    idle_mode = 0;
    accepted = 0;
    results_seen = 0;
    errs = 0;
    n_new = 0;
    n_dup = 0;
    n_full = 0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.char_code = '0;
    in_bus.glyph_width = '0;
    in_bus.left_space = '0;
    in_bus.right_space = '0;
    out_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults, then extremes of the glyph fields and duplicates
    apb_write(gasp_pkg::REG_SHEET_W, 256);
    apb_write(gasp_pkg::REG_LINE_H, 18);
    apb_write(gasp_pkg::REG_LINES, 14);
    add_glyph(16'h0000, 8'd0, 8'h80, 8'h7F);
    add_glyph(16'hFFFF, 8'd253, 8'h7F, 8'h80);
    add_glyph(16'h0001, 8'd254, 8'hFF, 8'h00);
    add_glyph(16'h0002, 8'd255, 8'h00, 8'hFF);
    add_glyph(16'h0000, 8'd7, 8'h55, 8'hAA);
    add_glyph(16'hFFFF, 8'd0, 8'hAA, 8'h55);
    add_glyph(16'h0003, 8'd255, 8'h01, 8'h01);
    add_glyph(16'h0004, 8'd255, 8'h01, 8'h01);
    add_random(300);
    drain();

    // a 4096 wide sheet, lines 257 high, the most lines
    apb_write(gasp_pkg::REG_SHEET_W, 4096);
    apb_write(gasp_pkg::REG_LINE_H, 257);
    apb_write(gasp_pkg::REG_LINES, 512);
    add_random(320);
    drain();

    // line count above the maximum
    apb_write(gasp_pkg::REG_SHEET_W, 1000);
    apb_write(gasp_pkg::REG_LINE_H, 100);
    apb_write(gasp_pkg::REG_LINES, 600);
    add_random(320);
    drain();

    // one line per sheet, narrow sheet: sheets open until the atlas is full
    apb_write(gasp_pkg::REG_SHEET_W, 200);
    apb_write(gasp_pkg::REG_LINE_H, 2);
    apb_write(gasp_pkg::REG_LINES, 0);
    add_random(320);
    drain();

    // sheet one unit wide: nothing new fits, known codes still answer
    apb_write(gasp_pkg::REG_SHEET_W, 1);
    apb_write(gasp_pkg::REG_LINE_H, 257);
    apb_write(gasp_pkg::REG_LINES, 1);
    add_glyph(16'h0000, 8'd0, 8'h00, 8'h00);
    add_glyph(16'h1234, 8'd0, 8'h00, 8'h00);
    add_random(320);
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d items over 5 register settings: %0d new, %0d duplicate, %0d refused",
             accepted, n_new, n_dup, n_full);
    $display("%0d result items checked", results_seen);
    if (errs == 0 && results_seen == accepted) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: glyph_atlas_shelf_packer.f
sv/gasp_pkg.sv
sv/gasp_if.sv
sv/gasp_ram.sv
sv/gasp_front.sv
sv/gasp_back.sv
sv/glyph_atlas_shelf_packer.sv
bench/testbench.sv
